// ===== rtl/kpt_pkg.sv =====
package kpt_pkg;

    // table geometry
    localparam int PENDING_DEPTH = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int FIRE_W        = $clog2(MAX_RESULTS);

    // field widths
    localparam int CMD_W  = 2;
    localparam int KEY_W  = 8;
    localparam int KIND_W = 2;
    localparam int THR_W  = 16;
    localparam int TICK_W = 32;

    // input commands
    localparam logic [CMD_W-1:0] CMD_DOWN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SHORT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

    // cell operations, broadcast to the whole row
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND     = 3'd1;
    localparam logic [OP_W-1:0] OP_SCAN_START = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN_STEP  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
    localparam logic [OP_W-1:0] OP_SHIFT_ALL  = 3'd5;

    // control into one cell
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sel;   // this cell is the target slot of append / scan start
    } t_cell_ctl;

    // what one cell hands to its lower neighbor
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TICK_W-1:0] since;
        logic              tok;
    } t_cell_data;

    // status seen by the controller
    typedef struct packed {
        logic hit;      // token here and key matches
        logic expired;  // held at least the threshold
    } t_cell_stat;

endpackage

// ===== rtl/kpt_if.sv =====
interface kpt_in_if;
    import kpt_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [KEY_W-1:0]  key_code;
    logic              long_capable;
    modport source (output valid, command, key_code, long_capable, input ready);
    modport sink   (input valid, command, key_code, long_capable, output ready);
endinterface

interface kpt_out_if;
    import kpt_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] press_kind;
    logic [KEY_W-1:0]  press_key;
    logic              last_of_run;
    modport source (output valid, press_kind, press_key, last_of_run, input ready);
    modport sink   (input valid, press_kind, press_key, last_of_run, output ready);
endinterface

interface kpt_cfg_if;
    import kpt_pkg::*;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/kpt_cell.sv =====
module kpt_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kpt_pkg::t_cell_ctl          i_ctl,
    input  kpt_pkg::t_cell_data         i_up,
    input  logic [kpt_pkg::KEY_W-1:0]   i_key,
    input  logic [kpt_pkg::TICK_W-1:0]  i_now,
    input  logic [kpt_pkg::THR_W-1:0]   i_thr,
    output kpt_pkg::t_cell_data         o_data,
    output kpt_pkg::t_cell_stat         o_stat
);
    import kpt_pkg::*;

    logic [KEY_W-1:0]  r_key;
    logic [TICK_W-1:0] r_since;
    logic              r_tok;
    logic              r_swept;
    logic              n_tok;
    logic              n_swept;
    logic [TICK_W-1:0] elapsed;

    // token and swept marks: the scan walks from newest to oldest
    always_comb begin
        n_tok   = r_tok;
        n_swept = r_swept;
        unique case (i_ctl.op)
            OP_SCAN_START: begin
                n_tok   = i_ctl.sel;
                n_swept = 1'b0;
            end
            OP_SCAN_STEP: begin
                n_tok   = i_up.tok;
                n_swept = r_swept | r_tok;
            end
            OP_REMOVE: begin
                n_tok   = 1'b0;
                n_swept = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_swept <= 1'b0;
        end else begin
            r_tok   <= n_tok;
            r_swept <= n_swept;
        end
    end

    // entry payload: load new press, or take the neighbor's entry on removal
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            OP_APPEND: begin
                if (i_ctl.sel) begin
                    r_key   <= i_key;
                    r_since <= i_now;
                end
            end
            OP_REMOVE: begin
                if (r_swept | r_tok) begin
                    r_key   <= i_up.key;
                    r_since <= i_up.since;
                end
            end
            OP_SHIFT_ALL: begin
                r_key   <= i_up.key;
                r_since <= i_up.since;
            end
            default: ;
        endcase
    end

    // elapsed time wraps at the counter width
    assign elapsed = i_now - r_since;

    assign o_stat.hit     = r_tok && (r_key == i_key);
    assign o_stat.expired = elapsed >= {{(TICK_W-THR_W){1'b0}}, i_thr};

    assign o_data.key   = r_key;
    assign o_data.since = r_since;
    assign o_data.tok   = r_tok;

endmodule

// ===== rtl/key_long_press_tracker.sv =====
// Key long-press tracker. Takes key-down, key-up and tick commands and reports
// short, long and dropped presses. Pending presses of long-capable keys sit in
// a row of PENDING_DEPTH cells, oldest in cell 0; removal shifts the younger
// cells down one place together. A key-down is taken while idle; one that
// yields a result passes through the emit state, and unused commands are
// ignored. A key-up with pending presses starts a scan that walks a token
// from the newest entry toward the oldest, one cell per cycle, and passes its
// result through the emit state. A tick fires expired presses from cell 0 at
// one per cycle while the output can take them, at most MAX_RESULTS per tick,
// and stops at the first entry that has not expired; presses left over fire
// on later ticks. Results pass through one output register, and the block
// takes a new command only once the previous one has finished. The threshold
// may be written at any time the block is idle; zero disables expiry on ticks
// and makes every matched release long.
module key_long_press_tracker (
    input  logic i_clk,
    input  logic i_rst_n,
    kpt_in_if.sink    i_in,
    kpt_out_if.source o_out,
    kpt_cfg_if.sink   i_cfg
);
    import kpt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIRE = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [THR_W-1:0]  r_thr;
    logic [FIRE_W-1:0] r_nfired, n_nfired;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic              r_ovalid, n_ovalid;
    logic [KIND_W-1:0] r_okind, n_okind;
    logic [KEY_W-1:0]  r_okey, n_okey;
    logic              r_olast, n_olast;

    logic [OP_W-1:0]   cell_op;
    logic              in_acc;
    logic              can_emit;
    logic              any_hit;
    logic              any_long;
    logic              fire_last;
    logic [CNT_W-1:0]  cnt_m1;
    logic [KEY_W-1:0]  cell_key;

    t_cell_ctl  ctl   [PENDING_DEPTH];
    t_cell_data data  [PENDING_DEPTH+1];
    t_cell_stat stat  [PENDING_DEPTH];
    logic [PENDING_DEPTH-1:0] hit_v;
    logic [PENDING_DEPTH-1:0] long_v;
    logic [PENDING_DEPTH-1:0] tok_v;

    // the row of cells; the top cell takes an empty entry from above
    assign data[PENDING_DEPTH] = '0;
    assign cnt_m1 = r_cnt - CNT_W'(1);

    // incoming key on append, held key while the scan runs
    assign cell_key = (r_state == S_IDLE) ? i_in.key_code : r_key;

    for (genvar g = 0; g < PENDING_DEPTH; g++) begin : g_cell
        always_comb begin
            ctl[g].op  = cell_op;
            ctl[g].sel = (cell_op == OP_APPEND) ? (r_cnt == CNT_W'(g))
                                                : (cnt_m1 == CNT_W'(g));
        end
        kpt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_up    (data[g+1]),
            .i_key   (cell_key),
            .i_now   (r_tick),
            .i_thr   (r_thr),
            .o_data  (data[g]),
            .o_stat  (stat[g])
        );
        assign hit_v[g]  = stat[g].hit;
        assign long_v[g] = stat[g].hit & stat[g].expired;
        assign tok_v[g]  = data[g].tok;
    end

    assign any_hit  = |hit_v;
    assign any_long = |long_v;

    // a fired press is the last of the tick unless the next oldest fires too and the per-tick limit is not yet reached
    assign fire_last = (r_cnt == CNT_W'(1)) || !stat[1].expired ||
                       (r_nfired == FIRE_W'(MAX_RESULTS - 1));

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign can_emit    = !r_ovalid || o_out.ready;

    // controller
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_tick   = r_tick;
        n_nfired = r_nfired;
        n_key    = r_key;
        n_kind   = r_kind;
        n_ovalid = r_ovalid && !o_out.ready;
        n_okind  = r_okind;
        n_okey   = r_okey;
        n_olast  = r_olast;
        cell_op  = OP_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key = i_in.key_code;
                    case (i_in.command)
                        CMD_DOWN: begin
                            if (!i_in.long_capable) begin
                                n_kind  = KIND_SHORT;
                                n_state = S_EMIT;
                            end else if (r_cnt == CNT_W'(PENDING_DEPTH)) begin
                                n_kind  = KIND_DROPPED;
                                n_state = S_EMIT;
                            end else begin
                                cell_op = OP_APPEND;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                        end
                        CMD_UP: begin
                            if (i_in.long_capable) begin
                                if (r_cnt == '0) begin
                                    n_kind  = KIND_SHORT;
                                    n_state = S_EMIT;
                                end else begin
                                    cell_op = OP_SCAN_START;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        CMD_TICK: begin
                            n_tick = r_tick + TICK_W'(1);
                            if (r_thr != '0) begin
                                n_nfired = '0;
                                n_state  = S_FIRE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (any_hit) begin
                    cell_op = OP_REMOVE;
                    n_cnt   = cnt_m1;
                    n_kind  = any_long ? KIND_LONG : KIND_SHORT;
                    n_state = S_EMIT;
                end else if (tok_v[0]) begin
                    n_kind  = KIND_SHORT;
                    n_state = S_EMIT;
                end else begin
                    cell_op = OP_SCAN_STEP;
                end
            end
            S_FIRE: begin
                if (r_cnt == '0 || !stat[0].expired) begin
                    n_state = S_IDLE;
                end else if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_LONG;
                    n_okey   = data[0].key;
                    n_olast  = fire_last;
                    cell_op  = OP_SHIFT_ALL;
                    n_cnt    = cnt_m1;
                    n_nfired = r_nfired + FIRE_W'(1);
                    if (fire_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_kind;
                    n_okey   = r_key;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_tick   <= '0;
            r_thr    <= '0;
            r_ovalid <= 1'b0;
            r_nfired <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_tick   <= n_tick;
            r_ovalid <= n_ovalid;
            r_nfired <= n_nfired;
            if (i_cfg.valid && i_cfg.ready) begin
                r_thr <= i_cfg.data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_kind  <= n_kind;
        r_okind <= n_okind;
        r_okey  <= n_okey;
        r_olast <= n_olast;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.press_kind  = r_okind;
    assign o_out.press_key   = r_okey;
    assign o_out.last_of_run = r_olast;

    // checks
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PENDING_DEPTH))
        else $error("pending count beyond table depth");

    a_tok_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_v))
        else $error("more than one scan token in the row");

    a_tok_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> $onehot(tok_v))
        else $error("scan running without a token");

    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.command == CMD_DOWN && i_in.long_capable &&
         r_cnt != CNT_W'(PENDING_DEPTH)) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("capable key-down did not grow the table");

endmodule
